### hw/rtl/dual_pid_speed_controller_core_assert.svh
// Assertion macros shared by the speed controller checkers.
`ifndef DUAL_PID_SPEED_CONTROLLER_CORE_ASSERT_SVH
`define DUAL_PID_SPEED_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define DPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dpsc_pkg.sv
// Shared widths, register indexes and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package dpsc_pkg;

  localparam int DATA_W    = 16;  // payload, gains, state
  localparam int INTV_W    = 10;  // interval register
  localparam int LIM_W     = 15;  // integral clamp register
  localparam int NUM_W     = 28;  // signed scaled setpoint / tick setpoint
  localparam int MAG_W     = NUM_W - 1;
  localparam int PERR_W    = NUM_W + 1;
  localparam int DERR_W    = DATA_W + 1;
  localparam int PROD_W    = PERR_W + DATA_W;
  localparam int SUM_W     = 48;
  localparam int DIV_STEPS = MAG_W;
  localparam int CNT_W     = 5;

  localparam logic [INTV_W-1:0] RST_INTERVAL = INTV_W'(20);
  localparam logic [DATA_W-1:0] RST_TTM      = DATA_W'(1);
  localparam logic [LIM_W-1:0]  RST_LIMIT    = LIM_W'(1000);
  localparam logic [DATA_W-1:0] RST_FF_GAIN  = DATA_W'(1);

  typedef enum logic [2:0] {
    REG_INTERVAL   = 3'd0,
    REG_TTM        = 3'd1,
    REG_LIMIT      = 3'd2,
    REG_OFFSET     = 3'd3,
    REG_FF_GAIN    = 3'd4,
    REG_PROP_GAIN  = 3'd5,
    REG_INTEG_GAIN = 3'd6,
    REG_DERIV_GAIN = 3'd7
  } dpsc_reg_e;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MSEL_FF,
    MSEL_P,
    MSEL_I,
    MSEL_D
  } dpsc_msel_e;

  typedef struct packed {
    logic       load;       // capture input word
    logic       chan;       // 0 left, 1 right
    logic       scale;      // target * 4 * interval
    logic       div_init;   // load divider
    logic       div_step;   // one restoring step
    logic       ticks;      // apply sign to quotient
    logic       err;        // P and D errors
    logic       zero_chan;  // zero setpoint: clear integral, drive 0
    logic       update;     // clamp integral, store state, seed sum
    logic       mul_en;
    dpsc_msel_e msel;
    logic       acc_en;     // add product into sum
    logic       sat;        // saturate sum into channel drive
    logic       publish;    // copy drives to output register
  } dpsc_cmd_t;

  typedef struct packed {
    logic ticks_zero;
  } dpsc_stat_t;

endpackage
`default_nettype wire

### hw/rtl/dpsc_ctrl.sv
// Sequencer for the speed controller: per-channel divide, error, MAC, saturate.
`timescale 1ns / 1ps
`default_nettype none
module dpsc_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  input  wire dpsc_pkg::dpsc_stat_t  stat_i,
  output dpsc_pkg::dpsc_cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCALE,
    S_DIV_INIT,
    S_DIV,
    S_TICKS,
    S_ERR,
    S_UPDATE,
    S_MUL,
    S_ACC,
    S_SAT,
    S_DONE
  } state_e;

  state_e                      state_q, state_d;
  logic                        chan_q, chan_d;
  logic [dpsc_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    chan_d      = chan_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o       = '0;
    cmd_o.chan  = chan_q;
    cmd_o.msel  = dpsc_pkg::MSEL_FF;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          chan_d     = 1'b0;
          state_d    = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = '0;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == dpsc_pkg::CNT_W'(dpsc_pkg::DIV_STEPS - 1)) begin
          state_d = S_TICKS;
        end
      end
      S_TICKS: begin
        cmd_o.ticks = 1'b1;
        state_d     = S_ERR;
      end
      S_ERR: begin
        cmd_o.err = 1'b1;
        if (stat_i.ticks_zero) begin
          cmd_o.zero_chan = 1'b1;
          if (!chan_q) begin
            chan_d  = 1'b1;
            state_d = S_SCALE;
          end else begin
            state_d = S_DONE;
          end
        end else begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        cnt_d        = '0;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.msel   = dpsc_pkg::dpsc_msel_e'(cnt_q[1:0]);
        cmd_o.acc_en = (cnt_q[1:0] != 2'd0);
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q[1:0] == 2'd3) begin
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = S_SAT;
      end
      S_SAT: begin
        cmd_o.sat = 1'b1;
        if (!chan_q) begin
          chan_d  = 1'b1;
          state_d = S_SCALE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.publish = 1'b1;
          out_valid_d   = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      chan_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chan_q      <= chan_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

### hw/rtl/dpsc_dp.sv
// Datapath: config registers, serial divider, shared multiplier, accumulator, state.
`timescale 1ns / 1ps
`default_nettype none
module dpsc_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [2:0]                          cfg_idx_i,
  input  wire logic [dpsc_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  target_left_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  target_right_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  measured_left_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  measured_right_i,
  input  wire dpsc_pkg::dpsc_cmd_t                 cmd_i,
  output dpsc_pkg::dpsc_stat_t                     stat_o,
  output logic signed [dpsc_pkg::DATA_W-1:0]       drive_left_o,
  output logic signed [dpsc_pkg::DATA_W-1:0]       drive_right_o
);

  localparam int DW    = dpsc_pkg::DATA_W;
  localparam int ACC_W = dpsc_pkg::PERR_W + 1;
  localparam int SC_W  = DW + dpsc_pkg::INTV_W + 1;
  localparam logic signed [dpsc_pkg::SUM_W-1:0] SatHi =
    dpsc_pkg::SUM_W'(2**(DW-1) - 1);
  localparam logic signed [dpsc_pkg::SUM_W-1:0] SatLo =
    dpsc_pkg::SUM_W'(-(2**(DW-1)));

  // configuration
  logic [dpsc_pkg::INTV_W-1:0] intv_q;
  logic [DW-1:0]               ttm_q;
  logic [dpsc_pkg::LIM_W-1:0]  lim_q;
  logic signed [DW-1:0]        off_q, ff_q, kp_q, ki_q, kd_q;

  // controller state, per channel
  logic signed [DW-1:0] last_q  [2];
  logic signed [DW-1:0] integ_q [2];
  logic signed [DW-1:0] drv_q   [2];

  // captured word and working registers
  logic signed [DW-1:0]                  tgt_q  [2];
  logic signed [DW-1:0]                  meas_q [2];
  logic signed [dpsc_pkg::NUM_W-1:0]     num_q, ticks_q;
  logic [dpsc_pkg::MAG_W-1:0]            quo_q;
  logic [DW-1:0]                         rem_q, dvs_q;
  logic signed [dpsc_pkg::PERR_W-1:0]    perr_q;
  logic signed [dpsc_pkg::DERR_W-1:0]    derr_q;
  logic signed [DW-1:0]                  iacc_q;
  logic signed [dpsc_pkg::PROD_W-1:0]    prod_q;
  logic signed [dpsc_pkg::SUM_W-1:0]     sum_q;
  logic signed [DW-1:0]                  dout_l_q, dout_r_q;

  logic signed [SC_W-1:0]              sc_prod;
  logic signed [dpsc_pkg::NUM_W-1:0]   num_d;
  logic [dpsc_pkg::MAG_W-1:0]          mag;
  logic [DW:0]                         rem_sh;
  logic                                rem_ge;
  logic signed [ACC_W-1:0]             acc_w, lim_pos, acc_c;
  logic signed [dpsc_pkg::PERR_W-1:0]  mul_a;
  logic signed [DW-1:0]                mul_b;
  logic signed [DW-1:0]                sat_val;

  logic ch;
  assign ch = cmd_i.chan;

  always_comb begin
    // setpoint scaling: |target*interval| < 2^25, so times four fits NUM_W
    sc_prod = tgt_q[ch] * $signed({1'b0, intv_q});
    num_d   = $signed({sc_prod[dpsc_pkg::NUM_W-3:0], 2'b00});
    mag     = num_q[dpsc_pkg::NUM_W-1] ? dpsc_pkg::MAG_W'(-num_q)
                                       : num_q[dpsc_pkg::MAG_W-1:0];

    // restoring divide step
    rem_sh = {rem_q, quo_q[dpsc_pkg::MAG_W-1]};
    rem_ge = (rem_sh >= {1'b0, dvs_q});

    // integral with anti-windup clamp
    lim_pos = $signed({{(ACC_W-dpsc_pkg::LIM_W){1'b0}}, lim_q});
    acc_w   = ACC_W'(integ_q[ch]) + ACC_W'(perr_q);
    if (acc_w > lim_pos) begin
      acc_c = lim_pos;
    end else if (acc_w < -lim_pos) begin
      acc_c = -lim_pos;
    end else begin
      acc_c = acc_w;
    end

    case (cmd_i.msel)
      dpsc_pkg::MSEL_FF: begin
        mul_a = dpsc_pkg::PERR_W'(ticks_q);
        mul_b = ff_q;
      end
      dpsc_pkg::MSEL_P: begin
        mul_a = perr_q;
        mul_b = kp_q;
      end
      dpsc_pkg::MSEL_I: begin
        mul_a = dpsc_pkg::PERR_W'(iacc_q);
        mul_b = ki_q;
      end
      dpsc_pkg::MSEL_D: begin
        mul_a = dpsc_pkg::PERR_W'(derr_q);
        mul_b = kd_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase

    if (sum_q > SatHi) begin
      sat_val = SatHi[DW-1:0];
    end else if (sum_q < SatLo) begin
      sat_val = SatLo[DW-1:0];
    end else begin
      sat_val = sum_q[DW-1:0];
    end
  end

  // config and loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intv_q     <= dpsc_pkg::RST_INTERVAL;
      ttm_q      <= dpsc_pkg::RST_TTM;
      lim_q      <= dpsc_pkg::RST_LIMIT;
      off_q      <= '0;
      ff_q       <= dpsc_pkg::RST_FF_GAIN;
      kp_q       <= '0;
      ki_q       <= '0;
      kd_q       <= '0;
      last_q[0]  <= '0;
      last_q[1]  <= '0;
      integ_q[0] <= '0;
      integ_q[1] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (dpsc_pkg::dpsc_reg_e'(cfg_idx_i))
          dpsc_pkg::REG_INTERVAL:   intv_q <= cfg_wdata_i[dpsc_pkg::INTV_W-1:0];
          dpsc_pkg::REG_TTM:        ttm_q  <= cfg_wdata_i;
          dpsc_pkg::REG_LIMIT:      lim_q  <= cfg_wdata_i[dpsc_pkg::LIM_W-1:0];
          dpsc_pkg::REG_OFFSET:     off_q  <= $signed(cfg_wdata_i);
          dpsc_pkg::REG_FF_GAIN:    ff_q   <= $signed(cfg_wdata_i);
          dpsc_pkg::REG_PROP_GAIN:  kp_q   <= $signed(cfg_wdata_i);
          dpsc_pkg::REG_INTEG_GAIN: ki_q   <= $signed(cfg_wdata_i);
          dpsc_pkg::REG_DERIV_GAIN: kd_q   <= $signed(cfg_wdata_i);
          default: ;
        endcase
      end
      if (cmd_i.zero_chan) begin
        integ_q[ch] <= '0;
      end
      if (cmd_i.update) begin
        integ_q[ch] <= acc_c[DW-1:0];
        last_q[ch]  <= meas_q[ch];
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q[0]  <= target_left_i;
      tgt_q[1]  <= target_right_i;
      meas_q[0] <= measured_left_i;
      meas_q[1] <= measured_right_i;
    end
    if (cmd_i.scale) begin
      num_q <= num_d;
    end
    if (cmd_i.div_init) begin
      quo_q <= mag;
      rem_q <= '0;
      dvs_q <= (ttm_q == '0) ? DW'(1) : ttm_q;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_ge ? DW'(rem_sh - {1'b0, dvs_q}) : rem_sh[DW-1:0];
      quo_q <= {quo_q[dpsc_pkg::MAG_W-2:0], rem_ge};
    end
    if (cmd_i.ticks) begin
      ticks_q <= num_q[dpsc_pkg::NUM_W-1] ? -$signed({1'b0, quo_q})
                                          : $signed({1'b0, quo_q});
    end
    if (cmd_i.err) begin
      perr_q <= dpsc_pkg::PERR_W'(ticks_q) - dpsc_pkg::PERR_W'(meas_q[ch]);
      derr_q <= dpsc_pkg::DERR_W'(meas_q[ch]) - dpsc_pkg::DERR_W'(last_q[ch]);
    end
    if (cmd_i.zero_chan) begin
      drv_q[ch] <= '0;
    end
    if (cmd_i.update) begin
      iacc_q <= acc_c[DW-1:0];
      sum_q  <= dpsc_pkg::SUM_W'(off_q);
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc_en) begin
      sum_q <= sum_q + dpsc_pkg::SUM_W'(prod_q);
    end
    if (cmd_i.sat) begin
      drv_q[ch] <= sat_val;
    end
    if (cmd_i.publish) begin
      dout_l_q <= drv_q[0];
      dout_r_q <= drv_q[1];
    end
  end

  assign stat_o.ticks_zero = (ticks_q == '0);
  assign drive_left_o      = dout_l_q;
  assign drive_right_o     = dout_r_q;

endmodule
`default_nettype wire

### hw/rtl/dual_pid_speed_controller_core.sv
// Top level of the dual-channel PID wheel speed controller.
//
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_ready_o | target_left/right_i, measured_left/right_i
//  out     | out_valid_o/out_ready_i | drive_left_o, drive_right_o
//  cfg     | cfg_we_i (no wait)     | cfg_idx_i, cfg_wdata_i
//
// One word at a time. Per channel: scale, divider load, restoring divide, sign fix
// and error; a nonzero tick setpoint adds integral update, four products on the
// shared multiplier plus final add, and saturate. Both channels run in turn before
// out_valid is raised; the divider dominates the work.
// Reset (async, active low) loads register defaults, clears speed and integral.
// A waiting result does not block the next word; only publishing waits for it.
`timescale 1ns / 1ps
`default_nettype none
module dual_pid_speed_controller_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [2:0]                          cfg_idx_i,
  input  wire logic [dpsc_pkg::DATA_W-1:0]         cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  target_left_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  target_right_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  measured_left_i,
  input  wire logic signed [dpsc_pkg::DATA_W-1:0]  measured_right_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [dpsc_pkg::DATA_W-1:0]       drive_left_o,
  output logic signed [dpsc_pkg::DATA_W-1:0]       drive_right_o
);

  // command/status between sequencer and datapath
  dpsc_pkg::dpsc_cmd_t  cmd;
  dpsc_pkg::dpsc_stat_t stat;

  // sequencer: owns the handshakes and the step order
  dpsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: registers, divider, multiplier-accumulator, output register
  dpsc_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .target_left_i    (target_left_i),
    .target_right_i   (target_right_i),
    .measured_left_i  (measured_left_i),
    .measured_right_i (measured_right_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .drive_left_o     (drive_left_o),
    .drive_right_o    (drive_right_o)
  );

endmodule
`default_nettype wire

### hw/rtl/dpsc_checker.sv
// Port-level checks for the speed controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "dual_pid_speed_controller_core_assert.svh"
module dpsc_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [dpsc_pkg::DATA_W-1:0] drive_left_o,
  input wire logic [dpsc_pkg::DATA_W-1:0] drive_right_o
);

  `DPSC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out word dropped")
  `DPSC_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(drive_left_o) && $stable(drive_right_o), "out word changed while stalled")
  `DPSC_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o, "second word taken while busy")
  `DPSC_ASSERT_NOW(a_result_from_work, $rose(out_valid_o), $past(!in_ready_o), "result with no word in flight")

endmodule

bind dual_pid_speed_controller_core dpsc_checker u_dpsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .drive_left_o  (drive_left_o),
  .drive_right_o (drive_right_o)
);
`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the dual-channel PID speed controller core.
module testbench;
  import dpsc_pkg::*;

  localparam int HALF_PERIOD     = 6;
  localparam int RESET_CYCLES    = 5;
  localparam int SETTLE_CYCLES   = 80;
  localparam int PRESSURE_CYCLES = 500;   // long sink hold-off
  localparam int WDOG_LIMIT      = 3000;  // cycles without any handshake
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 105;

  localparam logic signed [DATA_W-1:0] S_MAX = 16'sh7FFF;
  localparam logic signed [DATA_W-1:0] S_MIN = 16'sh8000;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct {
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;
  } drive_pair_t;

  // Every input starts at a known value; reset held low from time zero.
  logic                       clk_i            = 1'b0;
  logic                       rst_ni           = 1'b0;
  logic                       cfg_we_i         = 1'b0;
  logic [2:0]                 cfg_idx_i        = REG_INTERVAL;
  logic [DATA_W-1:0]          cfg_wdata_i      = '0;
  logic                       in_valid_i       = 1'b0;
  logic signed [DATA_W-1:0]   target_left_i    = '0;
  logic signed [DATA_W-1:0]   target_right_i   = '0;
  logic signed [DATA_W-1:0]   measured_left_i  = '0;
  logic signed [DATA_W-1:0]   measured_right_i = '0;
  logic                       out_ready_i      = 1'b0;
  logic                       in_ready_o;
  logic                       out_valid_o;
  logic signed [DATA_W-1:0]   drive_left_o;
  logic signed [DATA_W-1:0]   drive_right_o;

  // Shadow copy of the register file, loaded with the reset defaults.
  logic [INTV_W-1:0]          intv_q    = RST_INTERVAL;
  logic [DATA_W-1:0]          ttm_q     = RST_TTM;
  logic [LIM_W-1:0]           lim_q     = RST_LIMIT;
  logic signed [DATA_W-1:0]   offset_q  = '0;
  logic signed [DATA_W-1:0]   ff_gain_q = RST_FF_GAIN;
  logic signed [DATA_W-1:0]   kp_q      = '0;
  logic signed [DATA_W-1:0]   ki_q      = '0;
  logic signed [DATA_W-1:0]   kd_q      = '0;

  // Per-wheel controller state, index 0 left, 1 right.
  longint speed_prev[2] = '{0, 0};
  longint integ_err[2]  = '{0, 0};

  drive_pair_t drive_exp_q[$];
  int mismatches     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;   // sink hold-off request, picked up by the sink process
  int hold_left      = 0;

  dual_pid_speed_controller_core u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .target_left_i    (target_left_i),
    .target_right_i   (target_right_i),
    .measured_left_i  (measured_left_i),
    .measured_right_i (measured_right_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .drive_left_o     (drive_left_o),
    .drive_right_o    (drive_right_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // mm/s setpoint to ticks per interval, truncated toward zero; divisor 0 acts as 1.
  function automatic longint to_ticks(logic signed [DATA_W-1:0] tgt);
    longint div;
    div = (ttm_q == '0) ? 64'sd1 : longint'(ttm_q);
    return (longint'(tgt) * 4 * longint'(intv_q)) / div;
  endfunction

  // One wheel for one interval; updates that wheel's state as a side effect.
  function automatic logic signed [DATA_W-1:0] predict_drive(
    int ch, logic signed [DATA_W-1:0] tgt, logic signed [DATA_W-1:0] meas);
    longint ticks, perr, derr, acc, drv, lim;
    ticks = to_ticks(tgt);
    // Zero tick setpoint: integral cleared, drive zero, last speed untouched.
    if (ticks == 0) begin
      integ_err[ch] = 0;
      return '0;
    end
    lim  = longint'(lim_q);
    perr = ticks - longint'(meas);
    derr = longint'(meas) - speed_prev[ch];
    speed_prev[ch] = longint'(meas);
    // Anti-windup clamp; a zero limit pins the integral at zero.
    acc = integ_err[ch] + perr;
    if (acc > lim)  acc = lim;
    if (acc < -lim) acc = -lim;
    integ_err[ch] = acc;
    drv = longint'(offset_q) + ticks * longint'(ff_gain_q) + perr * longint'(kp_q)
        + acc * longint'(ki_q) + derr * longint'(kd_q);
    if (drv > 32767)  drv = 32767;
    if (drv < -32768) drv = -32768;
    return drv[DATA_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: pops the oldest expectation on each drive word taken,
  // then predicts and queues on each setpoint word taken.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_drive_words
    drive_pair_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (drive_exp_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected drive word, expected none, got left %0d right %0d",
                   $time, drive_left_o, drive_right_o);
        end else begin
          want = drive_exp_q.pop_front();
          if (drive_left_o !== want.left) begin
            mismatches++;
            $display("%0t: drive_left mismatch, expected %0d, got %0d",
                     $time, want.left, drive_left_o);
          end
          if (drive_right_o !== want.right) begin
            mismatches++;
            $display("%0t: drive_right mismatch, expected %0d, got %0d",
                     $time, want.right, drive_right_o);
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        want.left  = predict_drive(0, target_left_i, measured_left_i);
        want.right = predict_drive(1, target_right_i, measured_right_i);
        drive_exp_q.push_back(want);
      end
    end
  end

  // Sink: random per-cycle stalls, the odd longer stretch when stalling is on,
  // and the long hold-off that the back-pressure test asks for.
  always @(negedge clk_i) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(999) < 15) begin
      hold_left = $urandom_range(120, 5);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: ends the run once no handshake has happened for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < WDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Register write; the shadow copy follows at the same edge as the core.
  task automatic cfg_write(dpsc_reg_e idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_INTERVAL:   intv_q    = data[INTV_W-1:0];
      REG_TTM:        ttm_q     = data;
      REG_LIMIT:      lim_q     = data[LIM_W-1:0];
      REG_OFFSET:     offset_q  = data;
      REG_FF_GAIN:    ff_gain_q = data;
      REG_PROP_GAIN:  kp_q      = data;
      REG_INTEG_GAIN: ki_q      = data;
      REG_DERIV_GAIN: kd_q      = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one setpoint word and returns at the edge that takes it. Valid is
  // left high so a back-to-back word follows without a drop.
  task automatic send_word(logic signed [DATA_W-1:0] tl, logic signed [DATA_W-1:0] tr,
                           logic signed [DATA_W-1:0] ml, logic signed [DATA_W-1:0] mr);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < send_idle_pct) begin
      // mostly short gaps, some long enough to land anywhere in the divide
      gap = ($urandom_range(3) == 0) ? $urandom_range(90, 8) : $urandom_range(4, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i       <= 1'b1;
    target_left_i    <= tl;
    target_right_i   <= tr;
    measured_left_i  <= ml;
    measured_right_i <= mr;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every drive word is back and the core has gone quiet.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (drive_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 46; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 46; end
      IDLE_BOTH: begin send_idle_pct = 33; recv_stall_pct = 33; end
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return DATA_W'($urandom);
      1:       return '0;
      default: return DATA_W'(int'($urandom_range(64)) - 32);
    endcase
  endfunction

  // Fresh register set; upper bits of the narrow registers carry junk.
  task automatic randomise_config();
    logic [INTV_W-1:0] intv;
    logic [LIM_W-1:0]  lim;
    logic [DATA_W-1:0] ttm;
    case ($urandom_range(15))
      0:       intv = '0;
      1:       intv = INTV_W'($urandom_range(1023, 1001));
      2:       intv = INTV_W'(1);
      default: intv = INTV_W'($urandom_range(1000, 1));
    endcase
    case ($urandom_range(9))
      0:       ttm = '0;
      1:       ttm = 16'hFFFF;
      2:       ttm = DATA_W'($urandom);
      default: ttm = DATA_W'($urandom_range(400, 1));
    endcase
    case ($urandom_range(7))
      0:       lim = '0;
      1:       lim = 15'h7FFF;
      2:       lim = LIM_W'($urandom);
      default: lim = LIM_W'($urandom_range(2000, 1));
    endcase
    cfg_write(REG_INTERVAL, {6'($urandom), intv});
    cfg_write(REG_TTM, ttm);
    cfg_write(REG_LIMIT, {1'($urandom), lim});
    cfg_write(REG_OFFSET, ($urandom_range(3) == 0) ? DATA_W'($urandom)
                                                   : DATA_W'(int'($urandom_range(2000)) - 1000));
    cfg_write(REG_FF_GAIN, pick_gain());
    cfg_write(REG_PROP_GAIN, pick_gain());
    cfg_write(REG_INTEG_GAIN, pick_gain());
    cfg_write(REG_DERIV_GAIN, pick_gain());
  endtask

  // Setpoints: some zero, many small, some anywhere. Measured speeds mostly
  // sit near the tick setpoint so the integral works rather than pinning.
  task automatic send_random_word();
    logic signed [DATA_W-1:0] tgt[2];
    logic signed [DATA_W-1:0] meas[2];
    longint near;
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(7))
        0:       tgt[i] = '0;
        1, 2:    tgt[i] = DATA_W'($urandom);
        default: tgt[i] = DATA_W'(int'($urandom_range(400)) - 200);
      endcase
      if ($urandom_range(3) == 0) begin
        meas[i] = DATA_W'($urandom);
      end else begin
        near = to_ticks(tgt[i]) + longint'($urandom_range(40)) - 20;
        if (near > 32767)  near = 32767;
        if (near < -32768) near = -32768;
        meas[i] = near[DATA_W-1:0];
      end
    end
    send_word(tgt[0], tgt[1], meas[0], meas[1]);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset defaults: unity feedforward only, so drive is the tick setpoint.
  task automatic test_reset_defaults();
    set_idle(IDLE_NONE);
    send_word('0, '0, '0, '0);
    send_word(16'sd1, -16'sd1, '0, '0);
    send_word(S_MAX, S_MIN, S_MIN, S_MAX);         // saturates both ways
    send_word('0, 16'sd5, 16'sd100, -16'sd100);    // left zero keeps last speed
    drain_results();
  endtask

  // Every gain at an extreme, then offset alone at its negative limit.
  task automatic test_gain_extremes();
    cfg_write(REG_OFFSET, 16'h7FFF);
    cfg_write(REG_FF_GAIN, 16'h8000);
    cfg_write(REG_PROP_GAIN, 16'h7FFF);
    cfg_write(REG_INTEG_GAIN, 16'h8000);
    cfg_write(REG_DERIV_GAIN, 16'h7FFF);
    send_word(16'sd1, 16'sd1, S_MAX, S_MIN);
    send_word(-16'sd1, 16'sd100, S_MIN, S_MAX);
    send_word(16'sd5, -16'sd5, '0, '0);
    drain_results();
    cfg_write(REG_OFFSET, 16'h8000);
    cfg_write(REG_FF_GAIN, '0);
    cfg_write(REG_PROP_GAIN, '0);
    cfg_write(REG_INTEG_GAIN, '0);
    cfg_write(REG_DERIV_GAIN, '0);
    send_word(16'sd7, -16'sd7, 16'sd3, -16'sd3);
    send_word('0, 16'sd7, '0, '0);                 // zero setpoint overrides offset
    drain_results();
  endtask

  // Interval of zero, the top of the field (upper bits junk) and one.
  task automatic test_interval_edges();
    cfg_write(REG_OFFSET, '0);
    cfg_write(REG_FF_GAIN, 16'h0001);
    cfg_write(REG_PROP_GAIN, 16'h0002);
    cfg_write(REG_INTERVAL, '0);
    send_word(S_MAX, S_MIN, 16'sd5, 16'sd5);
    send_word(16'sd1, -16'sd1, '0, '0);
    drain_results();
    cfg_write(REG_INTERVAL, 16'hFFFF);
    send_word(16'sd8, -16'sd8, 16'sd9, -16'sd9);
    send_word(S_MAX, S_MIN, '0, '0);
    drain_results();
    cfg_write(REG_INTERVAL, 16'h0001);
    send_word(16'sd1, -16'sd1, 16'sd4, -16'sd4);
    send_word(-16'sd1, 16'sd1, 16'sd2, S_MAX);
    drain_results();
  endtask

  // Divisor of zero acts as one; the largest divisor truncates small setpoints to zero.
  task automatic test_divisor_edges();
    cfg_write(REG_INTERVAL, 16'd1000);
    cfg_write(REG_TTM, '0);
    send_word(16'sd3, -16'sd3, 16'sd11000, -16'sd12000);
    send_word(S_MIN, S_MAX, '0, '0);
    drain_results();
    cfg_write(REG_TTM, 16'hFFFF);
    send_word(16'sd16383, -16'sd16383, 16'sd1000, -16'sd1000);
    send_word(S_MIN, S_MAX, '0, '0);
    send_word(16'sd10, -16'sd10, 16'sd50, -16'sd50);
    drain_results();
  endtask

  // Integral alone drives the output: zero, full-scale and tiny clamps.
  task automatic test_integral_clamp();
    cfg_write(REG_INTERVAL, 16'd20);
    cfg_write(REG_TTM, 16'd1);
    cfg_write(REG_FF_GAIN, '0);
    cfg_write(REG_PROP_GAIN, '0);
    cfg_write(REG_INTEG_GAIN, 16'd1);
    cfg_write(REG_LIMIT, '0);
    send_word(16'sd100, -16'sd100, '0, '0);
    send_word(S_MAX, S_MIN, S_MIN, S_MAX);
    drain_results();
    cfg_write(REG_LIMIT, 16'hFFFF);
    send_word(S_MAX, S_MIN, S_MIN, S_MAX);         // clamps at both limits
    send_word(S_MAX, S_MIN, S_MIN, S_MAX);
    send_word(S_MIN, S_MAX, S_MAX, S_MIN);         // swings back through zero
    drain_results();
    cfg_write(REG_LIMIT, 16'd3);
    send_word(16'sd1, -16'sd1, '0, '0);
    send_word(16'sd1, -16'sd1, 16'sd200, -16'sd200);
    drain_results();
  endtask

  // Random registers, then a run of random words under one idling pattern.
  task automatic test_random_traffic(idle_mode_e mode, int words);
    drain_results();
    randomise_config();
    set_idle(mode);
    repeat (words) send_random_word();
  endtask

  // Sink holds off for a long stretch while words keep coming, so the core
  // fills its output register, finishes the next word and stalls its input.
  task automatic test_backpressure();
    drain_results();
    randomise_config();
    set_idle(IDLE_NONE);
    hold_req = PRESSURE_CYCLES;
    repeat (10) send_random_word();
    drain_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_gain_extremes();
    test_interval_edges();
    test_divisor_edges();
    test_integral_clamp();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      test_random_traffic(idle_mode_e'(p % 4), WORDS_PER_PHASE);
    end
    test_backpressure();

    // all words in; let any stray drive word show itself before judging
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && drive_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/dpsc_pkg.sv
hw/rtl/dpsc_ctrl.sv
hw/rtl/dpsc_dp.sv
hw/rtl/dual_pid_speed_controller_core.sv
hw/rtl/dpsc_checker.sv
dv/testbench.sv
